### hw/rtl/sobmf_pkg.sv
// Shared types and constants for the 3x3 mean / Sobel magnitude filter.
// No dependencies; used by every module of the filter.
`default_nettype none

package sobmf_pkg;

  // Field widths
  localparam int unsigned PixW   = 8;
  localparam int unsigned GradW  = 11;  // signed gradient, |g| <= 1020
  localparam int unsigned AbsW   = 10;
  localparam int unsigned SumW   = 12;  // sum of nine pixels, <= 2295
  localparam int unsigned SqW    = 2 * AbsW;
  localparam int unsigned MagW   = SqW + 1;
  localparam int unsigned ValW   = 16;  // magnitudes below 2^16 go to the root
  localparam int unsigned RootW  = ValW / 2;

  // Divide by nine: multiply by ceil(2^16 / 9) and drop 16 bits.
  // Exact for every sum up to 2295.
  localparam int unsigned RecipW     = 13;
  localparam logic [RecipW-1:0] MeanRecip = 13'd7282;
  localparam int unsigned MeanShift  = 16;
  localparam int unsigned MeanProdW  = SumW + RecipW;

  localparam logic [PixW-1:0] MaxPix = 8'hFF;

  // Mode codes
  localparam logic ModeMean  = 1'b0;
  localparam logic ModeSobel = 1'b1;

  // Pipeline: gradient, square, magnitude, then one stage per root bit
  localparam int unsigned NumStages = 3 + RootW;

  typedef struct packed {
    logic                    mode;
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
    logic [SumW-1:0]         sum;
  } grad_t;

  typedef struct packed {
    logic            mode;
    logic [SqW-1:0]  sqx;
    logic [SqW-1:0]  sqy;
    logic [PixW-1:0] mean;
  } sq_t;

  typedef struct packed {
    logic             mode;
    logic             big;
    logic [PixW-1:0]  mean;
    logic [ValW-1:0]  val;
    logic [RootW-1:0] root;
  } root_t;

endpackage

`default_nettype wire

### hw/rtl/sobmf_grad.sv
// First stage: Sobel gradients and the pixel sum of one window.
// Depends on sobmf_pkg.
`default_nettype none

module sobmf_grad (
  input  wire logic                         clk_i,
  input  wire logic                         adv_i,
  input  wire logic [sobmf_pkg::PixW-1:0]   p_tl_i,
  input  wire logic [sobmf_pkg::PixW-1:0]   p_tc_i,
  input  wire logic [sobmf_pkg::PixW-1:0]   p_tr_i,
  input  wire logic [sobmf_pkg::PixW-1:0]   p_ml_i,
  input  wire logic [sobmf_pkg::PixW-1:0]   p_mc_i,
  input  wire logic [sobmf_pkg::PixW-1:0]   p_mr_i,
  input  wire logic [sobmf_pkg::PixW-1:0]   p_bl_i,
  input  wire logic [sobmf_pkg::PixW-1:0]   p_bc_i,
  input  wire logic [sobmf_pkg::PixW-1:0]   p_br_i,
  input  wire logic                         mode_i,
  output      sobmf_pkg::grad_t             grad_o
);

  localparam int unsigned GrpW = sobmf_pkg::GradW - 1;

  logic [GrpW-1:0] left_s, right_s, top_s, bot_s;
  sobmf_pkg::grad_t grad_d, grad_q;

  // Weighted 1-2-1 column and row sums
  always_comb begin
    left_s  = GrpW'(p_tl_i) + GrpW'({p_ml_i, 1'b0}) + GrpW'(p_bl_i);
    right_s = GrpW'(p_tr_i) + GrpW'({p_mr_i, 1'b0}) + GrpW'(p_br_i);
    top_s   = GrpW'(p_tl_i) + GrpW'({p_tc_i, 1'b0}) + GrpW'(p_tr_i);
    bot_s   = GrpW'(p_bl_i) + GrpW'({p_bc_i, 1'b0}) + GrpW'(p_br_i);
    grad_d.mode = mode_i;
    grad_d.gx   = $signed({1'b0, left_s}) - $signed({1'b0, right_s});
    grad_d.gy   = $signed({1'b0, top_s}) - $signed({1'b0, bot_s});
    grad_d.sum  = sobmf_pkg::SumW'(p_tl_i) + sobmf_pkg::SumW'(p_tc_i)
                + sobmf_pkg::SumW'(p_tr_i) + sobmf_pkg::SumW'(p_ml_i)
                + sobmf_pkg::SumW'(p_mc_i) + sobmf_pkg::SumW'(p_mr_i)
                + sobmf_pkg::SumW'(p_bl_i) + sobmf_pkg::SumW'(p_bc_i)
                + sobmf_pkg::SumW'(p_br_i);
  end

  // Load on advance
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      grad_q <= grad_d;
    end
  end

  assign grad_o = grad_q;

endmodule

`default_nettype wire

### hw/rtl/sobmf_square.sv
// Second and third stages: gradient squares and mean by reciprocal multiply,
// then the squared magnitude with its overflow flag. Depends on sobmf_pkg.
`default_nettype none

module sobmf_square (
  input  wire logic              clk_i,
  input  wire logic              adv_sq_i,
  input  wire logic              adv_mag_i,
  input  wire sobmf_pkg::grad_t  grad_i,
  output      sobmf_pkg::root_t  root_o
);

  localparam int unsigned AbsW = sobmf_pkg::AbsW;
  localparam int unsigned SqW  = sobmf_pkg::SqW;
  localparam int unsigned MagW = sobmf_pkg::MagW;
  localparam int unsigned ValW = sobmf_pkg::ValW;

  logic signed [sobmf_pkg::GradW-1:0] ngx_s, ngy_s;
  logic [AbsW-1:0]                    ax_s, ay_s;
  logic [sobmf_pkg::MeanProdW-1:0]    mprod_s;
  logic [MagW-1:0]                    mag_s;
  sobmf_pkg::sq_t                     sq_d, sq_q;
  sobmf_pkg::root_t                   mag_d, mag_q;

  // Absolute gradients, squares and the mean
  always_comb begin
    ngx_s   = -grad_i.gx;
    ngy_s   = -grad_i.gy;
    ax_s    = grad_i.gx[sobmf_pkg::GradW-1] ? ngx_s[AbsW-1:0] : grad_i.gx[AbsW-1:0];
    ay_s    = grad_i.gy[sobmf_pkg::GradW-1] ? ngy_s[AbsW-1:0] : grad_i.gy[AbsW-1:0];
    mprod_s = sobmf_pkg::MeanProdW'(grad_i.sum)
            * sobmf_pkg::MeanProdW'(sobmf_pkg::MeanRecip);
    sq_d.mode = grad_i.mode;
    sq_d.sqx  = SqW'(ax_s) * SqW'(ax_s);
    sq_d.sqy  = SqW'(ay_s) * SqW'(ay_s);
    sq_d.mean = mprod_s[sobmf_pkg::MeanShift +: sobmf_pkg::PixW];
  end

  always_ff @(posedge clk_i) begin
    if (adv_sq_i) begin
      sq_q <= sq_d;
    end
  end

  // Squared magnitude; flag anything at or above 2^16 for clamping
  always_comb begin
    mag_s      = MagW'(sq_q.sqx) + MagW'(sq_q.sqy);
    mag_d.mode = sq_q.mode;
    mag_d.big  = |mag_s[MagW-1:ValW];
    mag_d.mean = sq_q.mean;
    mag_d.val  = mag_s[ValW-1:0];
    mag_d.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv_mag_i) begin
      mag_q <= mag_d;
    end
  end

  assign root_o = mag_q;

endmodule

`default_nettype wire

### hw/rtl/sobmf_root_step.sv
// One stage of the bit-by-bit integer square root: tries one result bit.
// Depends on sobmf_pkg.
`default_nettype none

module sobmf_root_step #(
  parameter int unsigned BitIdx = 0
) (
  input  wire logic              clk_i,
  input  wire logic              adv_i,
  input  wire sobmf_pkg::root_t  root_i,
  output      sobmf_pkg::root_t  root_o
);

  localparam int unsigned RootW = sobmf_pkg::RootW;
  localparam int unsigned ValW  = sobmf_pkg::ValW;
  localparam logic [RootW-1:0] BitMask = RootW'(1) << BitIdx;

  logic [RootW-1:0] cand_s;
  logic [ValW-1:0]  cand_sq_s;
  sobmf_pkg::root_t root_d, root_q;

  // Keep the trial bit if its square still fits under the value
  always_comb begin
    cand_s    = root_i.root | BitMask;
    cand_sq_s = ValW'(cand_s) * ValW'(cand_s);
    root_d    = root_i;
    if (cand_sq_s <= root_i.val) begin
      root_d.root = cand_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      root_q <= root_d;
    end
  end

  assign root_o = root_q;

endmodule

`default_nettype wire

### hw/rtl/sobel_or_mean_3x3_filter_unit.sv
// 3x3 window filter: mean of nine pixels or clamped Sobel gradient magnitude.
//
// Input channel valid_i/ready_o carries one window word: nine 8-bit pixels
// and filter_mode_i (0 mean, 1 Sobel). Output channel valid_o/ready_i
// carries one 8-bit filtered_pixel_o per window, in order.
// The datapath is an 11-stage pipeline: gradients and sum, squares and
// reciprocal-multiply mean, squared magnitude, then eight square-root
// stages that each settle one result bit. valid_o is the valid bit of the
// last stage, so a result is offered once its window has passed every stage;
// one window is taken every cycle while the output side keeps up. Each
// stage carries a valid bit; a stage loads whenever it is empty or its
// successor moves, so bubbles close up.
// When ready_i is low the last stage holds its word and stages fill behind
// it; ready_o drops once all 11 stages are full. Nothing is lost or
// repeated across a stall.
// Reset (rst_ni low, asynchronous) empties every stage; data registers
// are not cleared.
// Depends on sobmf_pkg, sobmf_grad, sobmf_square, sobmf_root_step.
`default_nettype none

module sobel_or_mean_3x3_filter_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output      logic                       ready_o,
  input  wire logic [sobmf_pkg::PixW-1:0] pixel_top_left_i,
  input  wire logic [sobmf_pkg::PixW-1:0] pixel_top_center_i,
  input  wire logic [sobmf_pkg::PixW-1:0] pixel_top_right_i,
  input  wire logic [sobmf_pkg::PixW-1:0] pixel_mid_left_i,
  input  wire logic [sobmf_pkg::PixW-1:0] pixel_mid_center_i,
  input  wire logic [sobmf_pkg::PixW-1:0] pixel_mid_right_i,
  input  wire logic [sobmf_pkg::PixW-1:0] pixel_bottom_left_i,
  input  wire logic [sobmf_pkg::PixW-1:0] pixel_bottom_center_i,
  input  wire logic [sobmf_pkg::PixW-1:0] pixel_bottom_right_i,
  input  wire logic                       filter_mode_i,
  output      logic                       valid_o,
  input  wire logic                       ready_i,
  output      logic [sobmf_pkg::PixW-1:0] filtered_pixel_o
);

  localparam int unsigned NumStages = sobmf_pkg::NumStages;
  localparam int unsigned RootW     = sobmf_pkg::RootW;
  localparam int unsigned RootBase  = 3;

  logic [NumStages-1:0] valid_d, valid_q;
  logic [NumStages-1:0] adv_s;
  sobmf_pkg::grad_t     grad_s;
  sobmf_pkg::root_t     chain_s [RootW+1];
  sobmf_pkg::root_t     last_s;

  // Stage enables: load when empty or when the next stage moves on
  always_comb begin
    adv_s[NumStages-1] = !valid_q[NumStages-1] || ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv_s[k] = !valid_q[k] || adv_s[k+1];
    end
  end

  // Advance valid bits alongside the data
  always_comb begin
    valid_d[0] = adv_s[0] ? valid_i : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      if (!adv_s[k]) begin
        valid_d[k] = valid_q[k];
      end else begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ready_o = adv_s[0];
  assign valid_o = valid_q[NumStages-1];

  sobmf_grad u_grad (
    .clk_i  (clk_i),
    .adv_i  (adv_s[0]),
    .p_tl_i (pixel_top_left_i),
    .p_tc_i (pixel_top_center_i),
    .p_tr_i (pixel_top_right_i),
    .p_ml_i (pixel_mid_left_i),
    .p_mc_i (pixel_mid_center_i),
    .p_mr_i (pixel_mid_right_i),
    .p_bl_i (pixel_bottom_left_i),
    .p_bc_i (pixel_bottom_center_i),
    .p_br_i (pixel_bottom_right_i),
    .mode_i (filter_mode_i),
    .grad_o (grad_s)
  );

  sobmf_square u_square (
    .clk_i     (clk_i),
    .adv_sq_i  (adv_s[1]),
    .adv_mag_i (adv_s[2]),
    .grad_i    (grad_s),
    .root_o    (chain_s[0])
  );

  // One root stage per result bit, most significant first
  for (genvar j = 0; j < RootW; j++) begin : g_root
    sobmf_root_step #(
      .BitIdx (RootW - 1 - j)
    ) u_step (
      .clk_i  (clk_i),
      .adv_i  (adv_s[RootBase + j]),
      .root_i (chain_s[j]),
      .root_o (chain_s[j+1])
    );
  end

  assign last_s = chain_s[RootW];

  // Pick mean, clamped value or root
  always_comb begin
    if (last_s.mode == sobmf_pkg::ModeSobel) begin
      filtered_pixel_o = last_s.big ? sobmf_pkg::MaxPix : last_s.root;
    end else begin
      filtered_pixel_o = last_s.mean;
    end
  end

  // Occupancy grows by one when a word enters and none leaves
  a_fill_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o && !(valid_o && ready_i)) |=>
      ($countones(valid_q) == $past($countones(valid_q)) + 1))
    else $error("pipeline occupancy did not grow on input-only cycle");

  // Occupancy shrinks by one when a word leaves and none enters
  a_fill_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(valid_i && ready_o) && valid_o && ready_i) |=>
      ($countones(valid_q) + 1 == $past($countones(valid_q))))
    else $error("pipeline occupancy did not shrink on output-only cycle");

  // Input stalls only behind a full pipeline held by the receiver
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> (valid_o && !ready_i && (&valid_q)))
    else $error("input stalled while pipeline had room");

  // Finished root is the floor of the square root
  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_s.mode == sobmf_pkg::ModeSobel && !last_s.big) |->
      ((18'(last_s.root) * 18'(last_s.root) <= 18'(last_s.val)) &&
       ((18'(last_s.root) + 18'd1) * (18'(last_s.root) + 18'd1) > 18'(last_s.val))))
    else $error("square root stage result out of range");

endmodule

`default_nettype wire

### tb/sv/sobel_or_mean_3x3_filter_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for sobel_or_mean_3x3_filter_unit: a directed table of
// windows, then random windows; typed table rows carry their own expected pixel,
// the rest are checked against an in-bench filter model. Depends on sobmf_pkg and the filter RTL; reads no files.

module sobel_or_mean_3x3_filter_unit_test;

  // Window positions, row by row
  localparam int TL = 0;
  localparam int TC = 1;
  localparam int TR = 2;
  localparam int ML = 3;
  localparam int MC = 4;
  localparam int MR = 5;
  localparam int BL = 6;
  localparam int BC = 7;
  localparam int BR = 8;

  localparam int NumRandom     = 1600;
  localparam int unsigned MagLimit = 65536;
  localparam int RecvIdlePct   = 60;

  localparam logic ModeMean  = sobmf_pkg::ModeMean;
  localparam logic ModeSobel = sobmf_pkg::ModeSobel;

  typedef logic [sobmf_pkg::PixW-1:0] pix_t;

  localparam pix_t MaxPix = sobmf_pkg::MaxPix;

  typedef struct packed {
    pix_t [8:0] pix;
    logic       mode;
  } window_t;

  typedef struct {
    window_t w;
    bit      typed;
    pix_t    val;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst_n;
  logic    win_valid;
  logic    win_ready;
  window_t win;
  logic    out_valid;
  logic    out_ready;
  pix_t    out_pixel;

  pix_t      pixel_due_q[$];
  pix_t      want_pixel;
  int        mismatch_count = 0;
  int        send_idle_pct;
  stim_row_t stim_tab[$];

  sobel_or_mean_3x3_filter_unit uut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .valid_i              (win_valid),
    .ready_o              (win_ready),
    .pixel_top_left_i     (win.pix[TL]),
    .pixel_top_center_i   (win.pix[TC]),
    .pixel_top_right_i    (win.pix[TR]),
    .pixel_mid_left_i     (win.pix[ML]),
    .pixel_mid_center_i   (win.pix[MC]),
    .pixel_mid_right_i    (win.pix[MR]),
    .pixel_bottom_left_i  (win.pix[BL]),
    .pixel_bottom_center_i(win.pix[BC]),
    .pixel_bottom_right_i (win.pix[BR]),
    .filter_mode_i        (win.mode),
    .valid_o              (out_valid),
    .ready_i              (out_ready),
    .filtered_pixel_o     (out_pixel)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Expected output pixel: truncated mean, or clamped Sobel magnitude
  function automatic pix_t filter_pixel_calc(window_t w);
    int unsigned sum;
    int unsigned mag;
    int unsigned root;
    int unsigned trial;
    int gx;
    int gy;
    int i;
    int b;
    if (w.mode == ModeMean) begin
      sum = 0;
      for (i = 0; i < 9; i++) sum += w.pix[i];
      return pix_t'(sum / 9);
    end
    gx = (int'(w.pix[TL]) + 2 * int'(w.pix[ML]) + int'(w.pix[BL]))
       - (int'(w.pix[TR]) + 2 * int'(w.pix[MR]) + int'(w.pix[BR]));
    gy = (int'(w.pix[TL]) + 2 * int'(w.pix[TC]) + int'(w.pix[TR]))
       - (int'(w.pix[BL]) + 2 * int'(w.pix[BC]) + int'(w.pix[BR]));
    mag = gx * gx + gy * gy;
    if (mag >= MagLimit) return MaxPix;
    // settle the root one bit at a time, MSB first
    root = 0;
    for (b = sobmf_pkg::PixW - 1; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= mag) root = trial;
    end
    return pix_t'(root);
  endfunction

  function automatic window_t make_win(int tl, int tc, int tr, int ml, int mc, int mr,
                                       int bl, int bc, int br, logic mode);
    window_t w;
    w.pix[TL] = pix_t'(tl);
    w.pix[TC] = pix_t'(tc);
    w.pix[TR] = pix_t'(tr);
    w.pix[ML] = pix_t'(ml);
    w.pix[MC] = pix_t'(mc);
    w.pix[MR] = pix_t'(mr);
    w.pix[BL] = pix_t'(bl);
    w.pix[BC] = pix_t'(bc);
    w.pix[BR] = pix_t'(br);
    w.mode    = mode;
    return w;
  endfunction

  task automatic add_row(window_t w, bit typed, pix_t val);
    stim_row_t r;
    r.w     = w;
    r.typed = typed;
    r.val   = val;
    stim_tab.push_back(r);
  endtask

  // Pixel level around base, clamped to the pixel range
  function automatic pix_t near_level(int base, int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return pix_t'(v);
  endfunction

  // Random window: flat noise, saturated, smooth, two-level edges, or near the clamp
  function automatic window_t random_window();
    window_t w;
    int i;
    int kind;
    int base;
    int lo;
    int hi;
    int spread;
    logic [8:0] mask;
    int hot [4];
    hot  = '{ML, MR, TC, BC};
    w.mode = logic'($urandom_range(0, 1));
    kind = $urandom_range(0, 5);
    case (kind)
      1: begin
        for (i = 0; i < 9; i++) w.pix[i] = $urandom_range(0, 1) ? MaxPix : '0;
      end
      2: begin
        base   = $urandom_range(0, 255);
        spread = $urandom_range(1, 12);
        for (i = 0; i < 9; i++) w.pix[i] = near_level(base, spread);
      end
      3: begin
        lo   = $urandom_range(0, 255);
        hi   = $urandom_range(0, 255);
        mask = 9'($urandom);
        for (i = 0; i < 9; i++) w.pix[i] = mask[i] ? pix_t'(hi) : pix_t'(lo);
      end
      4: begin
        for (i = 0; i < 9; i++) w.pix[i] = near_level(2, 2);
        w.pix[hot[$urandom_range(0, 3)]] = pix_t'($urandom_range(118, 138));
        w.mode = ModeSobel;
      end
      default: begin
        for (i = 0; i < 9; i++) w.pix[i] = pix_t'($urandom);
      end
    endcase
    return w;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic note_mismatch(string what, pix_t want, pix_t got);
    mismatch_count++;
    $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Hold the word on the port until it is taken
  task automatic present_window(window_t w, int gap);
    if (gap > 0) begin
      win_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    win_valid <= 1'b1;
    win       <= w;
    @(posedge clk);
    while (!win_ready) @(posedge clk);
  endtask

  // Let the pipeline drain completely
  task automatic hold_until_drained();
    win_valid <= 1'b0;
    while (pixel_due_q.size() != 0) @(posedge clk);
  endtask

  // Output side: runs of ready, broken by stalls
  initial begin
    int run;
    int stall;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      repeat (run) @(posedge clk);
      stall = pick_gap(RecvIdlePct);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Compare each taken word with the oldest expected pixel
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pixel_due_q.size() == 0) begin
        note_mismatch("result with nothing pending", 'x, out_pixel);
      end else begin
        want_pixel = pixel_due_q.pop_front();
        if (out_pixel !== want_pixel) note_mismatch("filtered_pixel", want_pixel, out_pixel);
      end
    end
  end

  // Stimulus
  initial begin
    int k;
    int n;
    window_t w;
    rst_n     <= 1'b0;
    win_valid <= 1'b0;
    win       <= '0;
    send_idle_pct = 20;

    // Extremes, the clamp boundary, the ignored center, and bit patterns
    add_row(make_win(0, 0, 0, 0, 0, 0, 0, 0, 0, ModeMean), 1, 8'd0);
    add_row(make_win(255, 255, 255, 255, 255, 255, 255, 255, 255, ModeMean), 1, 8'd255);
    add_row(make_win(0, 0, 0, 0, 0, 0, 0, 0, 0, ModeSobel), 1, 8'd0);
    add_row(make_win(255, 255, 255, 255, 255, 255, 255, 255, 255, ModeSobel), 1, 8'd0);
    add_row(make_win(0, 0, 0, 0, 8, 0, 0, 0, 0, ModeMean), 1, 8'd0);
    add_row(make_win(0, 0, 0, 0, 9, 0, 0, 0, 0, ModeMean), 1, 8'd1);
    add_row(make_win(0, 0, 0, 0, 255, 0, 0, 0, 0, ModeMean), 1, 8'd28);
    add_row(make_win(0, 0, 0, 0, 255, 0, 0, 0, 0, ModeSobel), 1, 8'd0);
    add_row(make_win(255, 0, 0, 255, 0, 0, 255, 0, 0, ModeSobel), 1, MaxPix);
    add_row(make_win(0, 0, 255, 0, 0, 255, 0, 0, 255, ModeSobel), 1, MaxPix);
    add_row(make_win(255, 255, 255, 0, 0, 0, 0, 0, 0, ModeSobel), 1, MaxPix);
    add_row(make_win(0, 0, 0, 0, 0, 0, 255, 255, 255, ModeSobel), 1, MaxPix);
    add_row(make_win(0, 0, 0, 128, 0, 0, 0, 0, 0, ModeSobel), 1, MaxPix);
    add_row(make_win(0, 0, 0, 127, 0, 0, 0, 0, 0, ModeSobel), 1, 8'd254);
    add_row(make_win(0, 0, 0, 0, 0, 127, 0, 0, 0, ModeSobel), 1, 8'd254);
    add_row(make_win(0, 128, 0, 0, 0, 0, 0, 0, 0, ModeSobel), 1, MaxPix);
    add_row(make_win(0, 0, 0, 0, 0, 0, 0, 127, 0, ModeSobel), 1, 8'd254);
    add_row(make_win(255, 0, 0, 0, 0, 0, 0, 0, 0, ModeSobel), 1, MaxPix);
    add_row(make_win(1, 0, 0, 0, 0, 0, 0, 0, 0, ModeSobel), 0, '0);
    add_row(make_win('hAA, 'h55, 'hAA, 'h55, 'hAA, 'h55, 'hAA, 'h55, 'hAA, ModeSobel), 0, '0);
    add_row(make_win('hAA, 'h55, 'hAA, 'h55, 'hAA, 'h55, 'hAA, 'h55, 'hAA, ModeMean), 0, '0);
    add_row(make_win('h55, 'hAA, 'h55, 'hAA, 'h55, 'hAA, 'h55, 'hAA, 'h55, ModeSobel), 0, '0);
    add_row(make_win('h55, 'hAA, 'h55, 'hAA, 'h55, 'hAA, 'h55, 'hAA, 'h55, ModeMean), 0, '0);
    add_row(make_win(1, 2, 3, 4, 5, 6, 7, 8, 9, ModeSobel), 0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (k = 0; k < stim_tab.size(); k++) begin
      present_window(stim_tab[k].w, pick_gap(send_idle_pct));
      pixel_due_q.push_back(stim_tab[k].typed ? stim_tab[k].val
                                              : filter_pixel_calc(stim_tab[k].w));
    end
    hold_until_drained();

    // Random windows; alternate busy, calm and gap-free stretches
    for (n = 0; n < NumRandom; n++) begin
      if (n % 400 == 200) hold_until_drained();
      if (n % 250 == 0) begin
        if ((n / 250) % 3 == 1) send_idle_pct = 0;
        else send_idle_pct = $urandom_range(0, 1) ? 40 : 10;
      end
      w = random_window();
      present_window(w, pick_gap(send_idle_pct));
      pixel_due_q.push_back(filter_pixel_calc(w));
    end
    win_valid <= 1'b0;

    // Drain, then watch for stray words
    while (pixel_due_q.size() != 0) @(posedge clk);
    repeat (2 * sobmf_pkg::NumStages) @(posedge clk);
    if (mismatch_count == 0 && pixel_due_q.size() == 0) begin
      $display("sobel_or_mean_3x3_filter_unit_test: PASS");
    end else begin
      $display("sobel_or_mean_3x3_filter_unit_test: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("sobel_or_mean_3x3_filter_unit_test: FAIL");
    $finish;
  end

endmodule
